>>> rtl/core/mdp_pkg.sv
// Shared types, codes and window tap tables for the masked dilation pass.
`timescale 1ns / 1ps
package mdp_pkg;

   localparam int unsigned CFG_W        = 13;
   localparam int unsigned HEIGHT_LIMIT = 4096;
   localparam int unsigned HW           = 13;   // eff height 1..4096
   localparam int unsigned YW           = 12;   // row index 0..4095
   localparam int unsigned TAP_W        = 4;
   localparam logic [TAP_W-1:0] TAP_CENTRE = 4'd0;
   localparam logic [TAP_W-1:0] TAP_LAST   = 4'd8;
   localparam logic [TAP_W-1:0] TAP_DRAIN  = 4'd9;

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_FLUSH = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      CSR_WIDTH    = 2'd0,
      CSR_HEIGHT   = 2'd1,
      CSR_DIAGONAL = 2'd2,
      CSR_NONE     = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_DECIDE,
      BK_DIV,
      BK_OUT
   } back_state_type;

   typedef struct packed {
      logic busy;      // back end still reading the line store
      logic popping;   // back end takes a descriptor this cycle
   } back_status_type;

   // Tap 0 is the centre, taps 1..8 walk the 3x3 window row by row.
   function automatic logic signed [1:0] tap_dx(input logic [TAP_W-1:0] k);
      logic signed [1:0] d;
      unique case (k)
         4'd1, 4'd4, 4'd6: d = -2'sd1;
         4'd3, 4'd5, 4'd8: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] tap_dy(input logic [TAP_W-1:0] k);
      logic signed [1:0] d;
      unique case (k)
         4'd1, 4'd2, 4'd3: d = -2'sd1;
         4'd6, 4'd7, 4'd8: d = 2'sd1;
         default:          d = 2'sd0;
      endcase
      return d;
   endfunction

endpackage

>>> rtl/core/mdp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module mdp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> rtl/core/mdp_queue.sv
// Small FIFO carrying output pixel descriptors from the front end to the back end.
`timescale 1ns / 1ps
module mdp_queue #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
endmodule

>>> rtl/core/mdp_front.sv
// Front end: takes requests, writes the line store and issues output pixel descriptors.
`timescale 1ns / 1ps
module mdp_front #(
   parameter int unsigned MAX_WIDTH = 4096,
   parameter int unsigned CB        = 16,
   parameter int unsigned RING      = 8200,
   parameter int unsigned EW        = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  mdp_pkg::action_type         action,
   input  logic [4*CB-1:0]             colour,
   input  logic                        pix_valid,
   input  logic                        pix_may_fill,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_width,
   input  logic [mdp_pkg::HW-1:0]      eff_height,
   input  logic                        cfg_clear,
   output logic                        wr_en,
   output logic [$clog2(RING)-1:0]     wr_addr,
   output logic [4*CB+1:0]             wr_data,
   output logic                        q_push,
   output logic [EW-1:0]               q_data,
   input  logic                        q_full,
   input  logic                        q_empty,
   input  mdp_pkg::back_status_type    back_status
);
   import mdp_pkg::*;

   localparam int unsigned AW = $clog2(RING);
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned LW = $clog2(MAX_WIDTH + 2);

   logic [AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [XW-1:0] in_x_ff, in_x_in, out_x_ff, out_x_in;
   logic [YW-1:0] in_y_ff, in_y_in, out_y_ff, out_y_in;
   logic [LW-1:0] lead_ff, lead_in;
   logic          in_done_ff, in_done_in, drain_ff, drain_in;
   logic          accept, take, emit, last_in_col, last_in, last_out_col, last_out;
   logic          lead_full;

   assign req_ready    = !drain_ff && !q_full;
   assign accept       = req_valid && req_ready;
   assign last_in_col  = (WW'(in_x_ff) == eff_width - WW'(1));
   assign last_in      = last_in_col && (HW'(in_y_ff) == eff_height - HW'(1));
   assign last_out_col = (WW'(out_x_ff) == eff_width - WW'(1));
   assign last_out     = last_out_col && (HW'(out_y_ff) == eff_height - HW'(1));
   // The window below a pixel is complete once one row and two pixels have gone by.
   assign lead_full    = (lead_ff >= LW'(eff_width) + LW'(1));
   assign take         = accept && (action == ACT_PIXEL) && !in_done_ff;
   assign emit         = (take && lead_full) ||
                         (accept && (action == ACT_FLUSH) && in_done_ff);

   always_comb begin
      wptr_in    = wptr_ff;
      rptr_in    = rptr_ff;
      in_x_in    = in_x_ff;
      in_y_in    = in_y_ff;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      lead_in    = lead_ff;
      in_done_in = in_done_ff;
      drain_in   = drain_ff;
      if (drain_ff && q_empty && !back_status.busy) begin
         drain_in = 1'b0;
      end
      if (take) begin
         wptr_in = (wptr_ff == AW'(RING - 1)) ? '0 : wptr_ff + AW'(1);
         if (last_in_col) begin
            in_x_in = '0;
            in_y_in = in_y_ff + YW'(1);
         end else begin
            in_x_in = in_x_ff + XW'(1);
         end
         if (last_in) begin
            in_done_in = 1'b1;
         end
         if (!lead_full) begin
            lead_in = lead_ff + LW'(1);
         end
      end
      if (emit) begin
         rptr_in = (rptr_ff == AW'(RING - 1)) ? '0 : rptr_ff + AW'(1);
         if (last_out_col) begin
            out_x_in = '0;
            out_y_in = out_y_ff + YW'(1);
         end else begin
            out_x_in = out_x_ff + XW'(1);
         end
         // The next frame waits until the back end has read this one out of the store.
         if (last_out) begin
            in_x_in    = '0;
            in_y_in    = '0;
            out_x_in   = '0;
            out_y_in   = '0;
            lead_in    = '0;
            in_done_in = 1'b0;
            drain_in   = 1'b1;
         end
      end
      if (cfg_clear) begin
         rptr_in    = wptr_ff;
         in_x_in    = '0;
         in_y_in    = '0;
         out_x_in   = '0;
         out_y_in   = '0;
         lead_in    = '0;
         in_done_in = 1'b0;
         drain_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff    <= '0;
         rptr_ff    <= '0;
         in_x_ff    <= '0;
         in_y_ff    <= '0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
         lead_ff    <= '0;
         in_done_ff <= 1'b0;
         drain_ff   <= 1'b0;
      end else begin
         wptr_ff    <= wptr_in;
         rptr_ff    <= rptr_in;
         in_x_ff    <= in_x_in;
         in_y_ff    <= in_y_in;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         lead_ff    <= lead_in;
         in_done_ff <= in_done_in;
         drain_ff   <= drain_in;
      end
   end

   assign wr_en   = take;
   assign wr_addr = wptr_ff;
   assign wr_data = {pix_may_fill, pix_valid, colour};
   assign q_push  = emit;
   assign q_data  = {last_out, out_y_ff, out_x_ff, rptr_ff};
endmodule

>>> rtl/core/mdp_back.sv
// Back end: gathers a pixel's 3x3 window, forms the weighted mean if filled and holds the result.
`timescale 1ns / 1ps
module mdp_back #(
   parameter int unsigned MAX_WIDTH = 4096,
   parameter int unsigned CB        = 16,
   parameter int unsigned RING      = 8200,
   parameter int unsigned EW        = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [EW-1:0]                  q_data,
   input  logic                           q_empty,
   output logic                           q_pop,
   input  logic [$clog2(MAX_WIDTH+1)-1:0] eff_width,
   input  logic [mdp_pkg::HW-1:0]         eff_height,
   input  logic                           diagonal_mode,
   output logic                           rd_en,
   output logic [$clog2(RING)-1:0]        rd_addr,
   input  logic [4*CB+1:0]                rd_data,
   output logic                           res_valid,
   input  logic                           res_ready,
   output logic [4*CB-1:0]                res_colour,
   output logic                           res_pix_valid,
   output logic                           res_filled,
   output logic                           res_frame_end,
   output mdp_pkg::back_status_type       back_status
);
   import mdp_pkg::*;

   localparam int unsigned AW = $clog2(RING);
   localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
   localparam int unsigned XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned SW = CB + 4;            // twelve weighted channel values
   localparam int unsigned DW = $clog2(SW + 1);
   localparam int unsigned OW = AW + 2;            // signed address arithmetic

   back_state_type    state_ff, state_in;
   logic [TAP_W-1:0]  k_ff, pend_k_ff;
   logic              pend_ff;
   logic [AW-1:0]     slot_ff;
   logic [XW-1:0]     cx_ff;
   logic [YW-1:0]     cy_ff;
   logic              fe_ff;
   logic [SW-1:0]     acc_ff [4];
   logic [3:0]        rem_ff [4];
   logic [3:0]        wsum_ff;
   logic              qual_ff;
   logic [4*CB-1:0]   cen_col_ff;
   logic              cen_valid_ff, cen_may_ff;
   logic [DW-1:0]     div_cnt_ff;
   logic [4*CB-1:0]   res_col_ff;
   logic              res_pix_valid_ff, res_filled_ff, res_fe_ff;

   logic signed [1:0] dx, dy, pdx, pdy;
   logic              x_ok, y_ok, tap_ok, issuing, fill, div_last;
   logic signed [OW-1:0] addr_raw, addr_fix;
   logic [SW-1:0]     num_next [4];
   logic [3:0]        rem_next [4];
   logic [4:0]        trial [4];

   assign dx = tap_dx(k_ff);
   assign dy = tap_dy(k_ff);
   assign x_ok = !((dx == -2'sd1) && (cx_ff == '0)) &&
                 !((dx == 2'sd1) && (WW'(cx_ff) == eff_width - WW'(1)));
   assign y_ok = !((dy == -2'sd1) && (cy_ff == '0)) &&
                 !((dy == 2'sd1) && (HW'(cy_ff) == eff_height - HW'(1)));
   assign issuing = (state_ff == BK_READ) && (k_ff <= TAP_LAST);
   assign tap_ok  = issuing && x_ok && y_ok;

   // Neighbour slot: centre slot plus or minus one row and one pixel, modulo the ring.
   always_comb begin
      addr_raw = $signed({2'b00, slot_ff}) + OW'($signed(dx));
      if (dy == 2'sd1) begin
         addr_raw = addr_raw + $signed(OW'(eff_width));
      end else if (dy == -2'sd1) begin
         addr_raw = addr_raw - $signed(OW'(eff_width));
      end
      if (addr_raw < 0) begin
         addr_fix = addr_raw + $signed(OW'(RING));
      end else if (addr_raw >= $signed(OW'(RING))) begin
         addr_fix = addr_raw - $signed(OW'(RING));
      end else begin
         addr_fix = addr_raw;
      end
   end

   assign rd_addr = addr_fix[AW-1:0];
   assign pdx     = tap_dx(pend_k_ff);
   assign pdy     = tap_dy(pend_k_ff);
   assign fill    = !cen_valid_ff && cen_may_ff && qual_ff && (wsum_ff != 4'd0);
   assign div_last = (div_cnt_ff == DW'(SW - 1));

   // One restoring division step per cycle for all four channels.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         trial[c] = {rem_ff[c], acc_ff[c][SW-1]};
         if (trial[c] >= {1'b0, wsum_ff}) begin
            rem_next[c] = 4'(trial[c] - {1'b0, wsum_ff});
            num_next[c] = {acc_ff[c][SW-2:0], 1'b1};
         end else begin
            rem_next[c] = trial[c][3:0];
            num_next[c] = {acc_ff[c][SW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (!q_empty) state_in = BK_READ;
         BK_READ:   if (k_ff == TAP_DRAIN) state_in = BK_DECIDE;
         BK_DECIDE: state_in = fill ? BK_DIV : BK_OUT;
         BK_DIV:    if (div_last) state_in = BK_OUT;
         BK_OUT:    if (res_ready) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      q_pop            = (state_ff == BK_IDLE) && !q_empty;
      rd_en            = tap_ok;
      res_valid        = (state_ff == BK_OUT);
      back_status.busy    = (state_ff == BK_READ) || q_pop;
      back_status.popping = q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= tap_ok;
      end
   end

   always_ff @(posedge clock) begin
      pend_k_ff <= k_ff;
      if (q_pop) begin
         {fe_ff, cy_ff, cx_ff, slot_ff} <= q_data;
         k_ff    <= TAP_CENTRE;
         wsum_ff <= '0;
         qual_ff <= 1'b0;
         for (int c = 0; c < 4; c++) begin
            acc_ff[c] <= '0;
         end
      end
      if (issuing) begin
         k_ff <= k_ff + TAP_W'(1);
      end
      if (pend_ff) begin
         if (pend_k_ff == TAP_CENTRE) begin
            cen_col_ff   <= rd_data[4*CB-1:0];
            cen_valid_ff <= rd_data[4*CB];
            cen_may_ff   <= rd_data[4*CB+1];
         end else if (rd_data[4*CB]) begin
            // Orthogonal neighbours carry weight two, diagonal ones weight one.
            if ((pdx != 2'sd0) && (pdy != 2'sd0)) begin
               wsum_ff <= wsum_ff + 4'd1;
               if (diagonal_mode) qual_ff <= 1'b1;
               for (int c = 0; c < 4; c++) begin
                  acc_ff[c] <= acc_ff[c] + SW'(rd_data[c*CB +: CB]);
               end
            end else begin
               wsum_ff <= wsum_ff + 4'd2;
               qual_ff <= 1'b1;
               for (int c = 0; c < 4; c++) begin
                  acc_ff[c] <= acc_ff[c] + SW'({rd_data[c*CB +: CB], 1'b0});
               end
            end
         end
      end
      if (state_ff == BK_DECIDE) begin
         div_cnt_ff       <= '0;
         res_pix_valid_ff <= fill | cen_valid_ff;
         res_filled_ff    <= fill;
         res_fe_ff        <= fe_ff;
         res_col_ff       <= cen_col_ff;
         for (int c = 0; c < 4; c++) begin
            rem_ff[c] <= '0;
         end
      end
      if (state_ff == BK_DIV) begin
         div_cnt_ff <= div_cnt_ff + DW'(1);
         for (int c = 0; c < 4; c++) begin
            acc_ff[c] <= num_next[c];
            rem_ff[c] <= rem_next[c];
            if (div_last) begin
               res_col_ff[c*CB +: CB] <= num_next[c][CB-1:0];
            end
         end
      end
   end

   assign res_colour    = res_col_ff;
   assign res_pix_valid = res_pix_valid_ff;
   assign res_filled    = res_filled_ff;
   assign res_frame_end = res_fe_ff;
endmodule

>>> rtl/core/masked_image_dilation_pass.sv
// Top level of the masked image dilation pass: register file, front end, queue, back end.
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    req_tdata, req_tuser
//  rsp      out        rsp_tvalid/tready    rsp_tdata, rsp_tlast
//  csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// The front end takes one request per cycle while the two-entry descriptor queue has room
// and no finished frame is draining. For each output pixel the back end makes up to nine
// line store reads, runs the bit-serial divider when the pixel is filled, then holds the result.
// After the last pixel of a frame the front end waits until the back end has read it out.
// Reset is synchronous; the line store has no reset and needs no clearing pass.
`timescale 1ns / 1ps
module masked_image_dilation_pass #(
   parameter int unsigned MAX_WIDTH    = 4096,
   parameter int unsigned CHANNEL_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // in_red, in_green, in_blue, in_alpha, in_valid, may_fill
   input  logic        req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // out_red, out_green, out_blue, out_alpha, out_valid, filled
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);
   import mdp_pkg::*;

   localparam int unsigned CB      = CHANNEL_BITS;
   localparam int unsigned QDEPTH  = 2;
   localparam int unsigned RING    = 2 * MAX_WIDTH + QDEPTH + 6;
   localparam int unsigned AW      = $clog2(RING);
   localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
   localparam int unsigned XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned EW      = 1 + YW + XW + AW;

   logic [CFG_W-1:0] width_ff, height_ff;
   logic             diag_ff, csr_write, cfg_clear;
   logic [WW-1:0]    eff_width;
   logic [HW-1:0]    eff_height;
   logic [4*CB-1:0]  colour, res_colour;
   logic             wr_en, rd_en, q_push, q_pop, q_full, q_empty;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [4*CB+1:0]  wr_data, rd_data;
   logic [EW-1:0]    q_wdata, q_rdata;
   logic             res_pix_valid, res_filled;
   back_status_type  back_status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign cfg_clear = csr_write && (csr_index_type'(csr_index) != CSR_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 13'd256;
         height_ff <= 13'd256;
         diag_ff   <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH:    width_ff  <= csr_data;
            CSR_HEIGHT:   height_ff <= csr_data;
            CSR_DIAGONAL: diag_ff   <= csr_data[0];
            CSR_NONE:     ;
            default:      ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         eff_width = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_width = WW'(MAX_WIDTH);
      end else begin
         eff_width = WW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_height = HW'(1);
      end else if (32'(height_ff) > HEIGHT_LIMIT) begin
         eff_height = HW'(HEIGHT_LIMIT);
      end else begin
         eff_height = HW'(height_ff);
      end
   end

   assign colour = {CB'(req_tdata[63:48]), CB'(req_tdata[47:32]),
                    CB'(req_tdata[31:16]), CB'(req_tdata[15:0])};

   mdp_front #(
      .MAX_WIDTH(MAX_WIDTH), .CB(CB), .RING(RING), .EW(EW)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .action       (action_type'(req_tuser)),
      .colour       (colour),
      .pix_valid    (req_tdata[64]),
      .pix_may_fill (req_tdata[65]),
      .eff_width    (eff_width),
      .eff_height   (eff_height),
      .cfg_clear    (cfg_clear),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .q_push       (q_push),
      .q_data       (q_wdata),
      .q_full       (q_full),
      .q_empty      (q_empty),
      .back_status  (back_status)
   );

   mdp_ram #(.WIDTH(4 * CB + 2), .DEPTH(RING)) u_line_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mdp_queue #(.WIDTH(EW), .DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   mdp_back #(
      .MAX_WIDTH(MAX_WIDTH), .CB(CB), .RING(RING), .EW(EW)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_data        (q_rdata),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .eff_width     (eff_width),
      .eff_height    (eff_height),
      .diagonal_mode (diag_ff),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .res_valid     (rsp_tvalid),
      .res_ready     (rsp_tready),
      .res_colour    (res_colour),
      .res_pix_valid (res_pix_valid),
      .res_filled    (res_filled),
      .res_frame_end (rsp_tlast),
      .back_status   (back_status)
   );

   assign rsp_tdata = {6'b0, res_filled, res_pix_valid,
                       16'(res_colour[3*CB +: CB]), 16'(res_colour[2*CB +: CB]),
                       16'(res_colour[CB +: CB]), 16'(res_colour[0 +: CB])};

   // The queue is never pushed while full, since the front end stalls requests first.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("descriptor queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      back_status.popping |-> !q_empty)
      else $error("descriptor queue underflow");

   // A filled pixel always leaves the pass valid.
   a_filled_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[65]) |-> rsp_tdata[64])
      else $error("filled pixel reported as invalid");

   // A line store read never hits the slot being written in the same cycle.
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("line store read and write collide");
endmodule
